@@ sv/gcse_pkg.sv @@
`default_nettype none

package gcse_pkg;

	// Field and register widths
	localparam int SIZE_W    = 11;
	localparam int CELL_W    = 10;
	localparam int MASK_W    = 8;
	localparam int VTX_W     = 30;
	localparam int SCHEME_W  = 2;
	localparam int REG_IDX_W = 2;
	localparam int PLANE_W   = 2 * SIZE_W;
	localparam int OFF_W     = PLANE_W + 1;

	// Simplices per cell and the select width that spans them
	localparam int NSIMP = 6;
	localparam int SEL_W = 3;

	// Request queue between front and back
	localparam int QDEPTH = 4;
	localparam int QPTR_W = 2;
	localparam int QCNT_W = 3;

	typedef enum logic [REG_IDX_W-1:0] {
		REG_SIZE_X,
		REG_SIZE_Y,
		REG_SIZE_Z,
		REG_SPLIT_SCHEME
	} reg_index_t;

	localparam logic [SCHEME_W-1:0] SCHEME_SIX  = 2'd0;
	localparam logic [SCHEME_W-1:0] SCHEME_FIVE = 2'd1;

	typedef enum logic [1:0] {
		MODE_NONE,
		MODE_SIX,
		MODE_FIVE,
		MODE_TRI
	} mode_t;

	typedef enum logic [2:0] {
		TAB_SIX,
		TAB_FIVE_ODD,
		TAB_FIVE_EVEN,
		TAB_TRI_ODD,
		TAB_TRI_EVEN
	} tab_t;

	// Classification settings derived from the size and scheme registers
	typedef struct packed {
		mode_t             mode;
		logic [SIZE_W-1:0] lim_a;
		logic [SIZE_W-1:0] lim_b;
		logic [SIZE_W-1:0] lim_c;
	} class_cfg_t;

	// Index strides: one row step and one plane step
	typedef struct packed {
		logic [SIZE_W-1:0]  row;
		logic [PLANE_W-1:0] plane;
	} stride_t;

	// One queued cell request
	typedef struct packed {
		logic [VTX_W-1:0] base;
		tab_t             tab;
		logic [NSIMP-1:0] keep;
	} entry_t;

	typedef logic [2:0] corner_t;

	// Corner codes are dx + 2*dy + 4*dz
	localparam corner_t TET_SIX [6][4] = '{
		'{3'd2, 3'd3, 3'd7, 3'd0}, '{3'd0, 3'd1, 3'd7, 3'd3}, '{3'd0, 3'd1, 3'd7, 3'd5},
		'{3'd6, 3'd7, 3'd2, 3'd0}, '{3'd6, 3'd4, 3'd0, 3'd7}, '{3'd0, 3'd4, 3'd7, 3'd5}
	};
	localparam corner_t TET_FIVE_ODD [5][4] = '{
		'{3'd0, 3'd2, 3'd3, 3'd6}, '{3'd6, 3'd7, 3'd3, 3'd5}, '{3'd0, 3'd1, 3'd3, 3'd5},
		'{3'd0, 3'd4, 3'd5, 3'd6}, '{3'd0, 3'd5, 3'd6, 3'd3}
	};
	localparam corner_t TET_FIVE_EVEN [5][4] = '{
		'{3'd0, 3'd2, 3'd1, 3'd4}, '{3'd4, 3'd7, 3'd1, 3'd5}, '{3'd7, 3'd1, 3'd3, 3'd2},
		'{3'd2, 3'd7, 3'd6, 3'd4}, '{3'd4, 3'd1, 3'd7, 3'd2}
	};
	localparam corner_t TRI_ODD [2][3] = '{
		'{3'd2, 3'd0, 3'd1}, '{3'd2, 3'd1, 3'd3}
	};
	localparam corner_t TRI_EVEN [2][3] = '{
		'{3'd0, 3'd1, 3'd3}, '{3'd0, 3'd2, 3'd3}
	};

	function automatic logic is_tri(tab_t tab);
		return (tab == TAB_TRI_ODD) || (tab == TAB_TRI_EVEN);
	endfunction

	// Number of simplices in a pattern
	function automatic logic [SEL_W-1:0] tab_count(tab_t tab);
		logic [SEL_W-1:0] n;
		case (tab)
			TAB_SIX:                      n = 3'd6;
			TAB_FIVE_ODD, TAB_FIVE_EVEN:  n = 3'd5;
			TAB_TRI_ODD, TAB_TRI_EVEN:    n = 3'd2;
			default:                      n = 3'd0;
		endcase
		return n;
	endfunction

	// Corner code of vertex v of simplex s; zero outside the pattern
	function automatic corner_t corner_code(tab_t tab, logic [SEL_W-1:0] s, logic [1:0] v);
		corner_t c;
		c = '0;
		case (tab)
			TAB_SIX:       if (s < 3'd6) c = TET_SIX[s][v];
			TAB_FIVE_ODD:  if (s < 3'd5) c = TET_FIVE_ODD[s][v];
			TAB_FIVE_EVEN: if (s < 3'd5) c = TET_FIVE_EVEN[s][v];
			TAB_TRI_ODD:   if (s < 3'd2 && v < 2'd3) c = TRI_ODD[s[0]][v];
			TAB_TRI_EVEN:  if (s < 3'd2 && v < 2'd3) c = TRI_EVEN[s[0]][v];
			default:       c = '0;
		endcase
		return c;
	endfunction

	// Set of corners that one simplex touches
	function automatic logic [MASK_W-1:0] simplex_mask(tab_t tab, logic [SEL_W-1:0] s);
		logic [MASK_W-1:0] m;
		corner_t c;
		m = '0;
		for (int v = 0; v < 4; v++) begin
			c = corner_code(tab, s, 2'(v));
			if (v < 3 || !is_tri(tab))
				m[c] = 1'b1;
		end
		return m;
	endfunction

endpackage

`default_nettype wire

@@ sv/gcse_front.sv @@
`default_nettype none

module gcse_front import gcse_pkg::*; #(
	parameter int MAX_AXIS_POINTS = 1024
) (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 start,
	output logic                      busy,
	input  wire logic [CELL_W-1:0]    cell_i,
	input  wire logic [CELL_W-1:0]    cell_j,
	input  wire logic [CELL_W-1:0]    cell_k,
	input  wire logic [MASK_W-1:0]    corner_invalid,
	input  wire logic                 cfg_we,
	input  wire logic [REG_IDX_W-1:0] cfg_index,
	input  wire logic [SIZE_W-1:0]    cfg_data,
	input  wire logic                 q_full,
	output logic                      push,
	output entry_t                    push_entry,
	output stride_t                   stride
);

	localparam logic [31:0] MAX_PTS = 32'(MAX_AXIS_POINTS);

	function automatic logic size_ok(logic [SIZE_W-1:0] s);
		return (s != '0) && ({{(32 - SIZE_W){1'b0}}, s} <= MAX_PTS);
	endfunction

	logic [SIZE_W-1:0]   size_x_q, size_y_q, size_z_q;
	logic [SCHEME_W-1:0] scheme_q;

	logic                all_ok, vol;
	logic [SIZE_W-1:0]   dima, dimb;
	class_cfg_t          cls_d, cls_q;
	stride_t             stride_d, stride_q;

	logic                stall, accept;

	logic                valid_s1;
	logic [CELL_W-1:0]   i_s1, j_s1, k_s1;
	logic [MASK_W-1:0]   bad_s1;

	logic                in_range, par3, par2;
	tab_t                tab_d;
	logic [NSIMP-1:0]    keep_d;
	logic [PLANE_W+CELL_W-1:0] pk_d;
	logic [SIZE_W+CELL_W-1:0]  pj_d;

	logic                      valid_s2;
	logic [VTX_W-1:0]          pk_s2;
	logic [SIZE_W+CELL_W-1:0]  pj_s2;
	logic [CELL_W-1:0]         i_s2;
	tab_t                      tab_s2;
	logic [NSIMP-1:0]          keep_s2;

	logic                valid_s3;
	logic [VTX_W-1:0]    base_s3;
	tab_t                tab_s3;
	logic [NSIMP-1:0]    keep_s3;

	// Write configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			size_x_q <= SIZE_W'(1);
			size_y_q <= SIZE_W'(1);
			size_z_q <= SIZE_W'(1);
			scheme_q <= SCHEME_SIX;
		end else if (cfg_we) begin
			case (reg_index_t'(cfg_index))
				REG_SIZE_X:       size_x_q <= cfg_data;
				REG_SIZE_Y:       size_y_q <= cfg_data;
				REG_SIZE_Z:       size_z_q <= cfg_data;
				REG_SPLIT_SCHEME: scheme_q <= cfg_data[SCHEME_W-1:0];
				default:          ;
			endcase
		end
	end

	// Derive mode, limits and strides from the registers
	always_comb begin
		all_ok = size_ok(size_x_q) && size_ok(size_y_q) && size_ok(size_z_q);
		vol = all_ok && (size_x_q > SIZE_W'(1)) && (size_y_q > SIZE_W'(1))
			&& (size_z_q > SIZE_W'(1));
		dima = SIZE_W'(1);
		dimb = SIZE_W'(1);
		if (size_z_q == SIZE_W'(1)) begin
			dima = size_x_q;
			dimb = size_y_q;
		end else if (size_y_q == SIZE_W'(1)) begin
			dima = size_x_q;
			dimb = size_z_q;
		end else if (size_x_q == SIZE_W'(1)) begin
			dima = size_y_q;
			dimb = size_z_q;
		end
		cls_d.mode = MODE_NONE;
		if (all_ok) begin
			if (vol) begin
				if (scheme_q == SCHEME_SIX)
					cls_d.mode = MODE_SIX;
				else if (scheme_q == SCHEME_FIVE)
					cls_d.mode = MODE_FIVE;
			end else if (dima > SIZE_W'(1) && dimb > SIZE_W'(1)) begin
				cls_d.mode = MODE_TRI;
			end
		end
		cls_d.lim_a    = vol ? size_x_q - SIZE_W'(1) : dima - SIZE_W'(1);
		cls_d.lim_b    = vol ? size_y_q - SIZE_W'(1) : dimb - SIZE_W'(1);
		cls_d.lim_c    = vol ? size_z_q - SIZE_W'(1) : '1;
		stride_d.row   = vol ? size_x_q : dima;
		stride_d.plane = vol ? PLANE_W'(size_x_q) * PLANE_W'(size_y_q) : '0;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cls_q    <= '0;
			stride_q <= '0;
		end else begin
			cls_q    <= cls_d;
			stride_q <= stride_d;
		end
	end

	assign stride = stride_q;

	// Hold the pipe when the last stage has a request and the queue is full
	assign stall  = valid_s3 && (keep_s3 != '0) && q_full;
	assign busy   = stall;
	assign accept = start && !stall;
	assign push   = valid_s3 && (keep_s3 != '0) && !q_full;
	assign push_entry = '{base: base_s3, tab: tab_s3, keep: keep_s3};

	// Classify the cell: pattern, kept simplices, index products
	always_comb begin
		in_range = (cls_q.mode != MODE_NONE)
			&& ({1'b0, i_s1} < cls_q.lim_a)
			&& ({1'b0, j_s1} < cls_q.lim_b)
			&& ({1'b0, k_s1} < cls_q.lim_c);
		par3 = i_s1[0] ^ j_s1[0] ^ k_s1[0];
		par2 = i_s1[0] ^ j_s1[0];
		case (cls_q.mode)
			MODE_SIX:  tab_d = TAB_SIX;
			MODE_FIVE: tab_d = par3 ? TAB_FIVE_ODD : TAB_FIVE_EVEN;
			MODE_TRI:  tab_d = par2 ? TAB_TRI_ODD : TAB_TRI_EVEN;
			default:   tab_d = TAB_SIX;
		endcase
		for (int s = 0; s < NSIMP; s++) begin
			keep_d[s] = in_range && (SEL_W'(s) < tab_count(tab_d))
				&& ((bad_s1 & simplex_mask(tab_d, SEL_W'(s))) == '0);
		end
		pk_d = (PLANE_W + CELL_W)'(stride_q.plane) * (PLANE_W + CELL_W)'(k_s1);
		pj_d = (SIZE_W + CELL_W)'(stride_q.row) * (SIZE_W + CELL_W)'(j_s1);
	end

	// Advance valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
		end else if (!stall) begin
			valid_s1 <= accept;
			valid_s2 <= valid_s1;
			valid_s3 <= valid_s2;
		end
	end

	// Advance payload
	always_ff @(posedge clk) begin
		if (!stall) begin
			i_s1    <= cell_i;
			j_s1    <= cell_j;
			k_s1    <= cell_k;
			bad_s1  <= corner_invalid;
			pk_s2   <= pk_d[VTX_W-1:0];
			pj_s2   <= pj_d;
			i_s2    <= i_s1;
			tab_s2  <= tab_d;
			keep_s2 <= keep_d & {NSIMP{valid_s1}};
			base_s3 <= pk_s2 + VTX_W'(pj_s2) + VTX_W'(i_s2);
			tab_s3  <= tab_s2;
			keep_s3 <= keep_s2;
		end
	end

endmodule

`default_nettype wire

@@ sv/gcse_queue.sv @@
`default_nettype none

module gcse_queue import gcse_pkg::*; (
	input  wire logic   clk,
	input  wire logic   arst_n,
	input  wire logic   push,
	input  wire entry_t din,
	input  wire logic   pop,
	output entry_t      dout,
	output logic        full,
	output logic        empty
);

	entry_t              mem_q [QDEPTH];
	logic [QPTR_W-1:0]   wr_q, rd_q;
	logic [QCNT_W-1:0]   cnt_q;

	// Store request
	always_ff @(posedge clk) begin
		if (push)
			mem_q[wr_q] <= din;
	end

	// Move pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push)
				wr_q <= wr_q + QPTR_W'(1);
			if (pop)
				rd_q <= rd_q + QPTR_W'(1);
			if (push && !pop)
				cnt_q <= cnt_q + QCNT_W'(1);
			else if (pop && !push)
				cnt_q <= cnt_q - QCNT_W'(1);
		end
	end

	assign dout  = mem_q[rd_q];
	assign full  = (cnt_q == QCNT_W'(QDEPTH));
	assign empty = (cnt_q == '0);

endmodule

`default_nettype wire

@@ sv/gcse_back.sv @@
`default_nettype none

module gcse_back import gcse_pkg::*; (
	input  wire logic    clk,
	input  wire logic    arst_n,
	input  wire stride_t stride,
	input  wire logic    q_empty,
	input  wire entry_t  q_head,
	output logic         pop,
	output logic             result_strobe,
	output logic [VTX_W-1:0] vertex_a,
	output logic [VTX_W-1:0] vertex_b,
	output logic [VTX_W-1:0] vertex_c,
	output logic [VTX_W-1:0] vertex_d,
	output logic             is_triangle,
	output logic             last_of_cell
);

	logic                cur_valid_q;
	logic [VTX_W-1:0]    cur_base_q;
	tab_t                cur_tab_q;
	logic [NSIMP-1:0]    cur_keep_q;

	logic [SEL_W-1:0]    sel;
	logic [NSIMP-1:0]    rest;
	logic                last, need_load, tri_d;
	corner_t             c;
	logic [OFF_W-1:0]    off;
	logic [VTX_W-1:0]    vert_d [4];

	logic                strobe_q, tri_q, last_q;
	logic [VTX_W-1:0]    va_q, vb_q, vc_q, vd_q;

	// Pick the lowest kept simplex and build its vertex indices
	always_comb begin
		sel = '0;
		for (int s = NSIMP - 1; s >= 0; s--) begin
			if (cur_keep_q[s])
				sel = SEL_W'(s);
		end
		rest      = cur_keep_q & ~(NSIMP'(1) << sel);
		last      = (rest == '0);
		need_load = !cur_valid_q || last;
		pop       = need_load && !q_empty;
		tri_d     = is_tri(cur_tab_q);
		for (int v = 0; v < 4; v++) begin
			c   = corner_code(cur_tab_q, sel, 2'(v));
			off = (c[2] ? OFF_W'(stride.plane) : '0)
				+ (c[1] ? OFF_W'(stride.row) : '0)
				+ OFF_W'(c[0]);
			vert_d[v] = cur_base_q + VTX_W'(off);
		end
		if (tri_d)
			vert_d[3] = '0;
	end

	// Track the cell in work
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cur_valid_q <= 1'b0;
			strobe_q    <= 1'b0;
		end else begin
			if (pop)
				cur_valid_q <= 1'b1;
			else if (need_load)
				cur_valid_q <= 1'b0;
			strobe_q <= cur_valid_q;
		end
	end

	// Load the next request or drop the emitted simplex
	always_ff @(posedge clk) begin
		if (pop) begin
			cur_base_q <= q_head.base;
			cur_tab_q  <= q_head.tab;
			cur_keep_q <= q_head.keep;
		end else begin
			cur_keep_q <= rest;
		end
		if (cur_valid_q) begin
			va_q   <= vert_d[0];
			vb_q   <= vert_d[1];
			vc_q   <= vert_d[2];
			vd_q   <= vert_d[3];
			tri_q  <= tri_d;
			last_q <= last;
		end
	end

	assign result_strobe = strobe_q;
	assign vertex_a      = va_q;
	assign vertex_b      = vb_q;
	assign vertex_c      = vc_q;
	assign vertex_d      = vd_q;
	assign is_triangle   = tri_q;
	assign last_of_cell  = last_q;

endmodule

`default_nettype wire

@@ sv/grid_cell_simplex_emitter_top.sv @@
// Grid cell simplex emitter: cuts one grid cell into tetrahedra or triangles.
// Request channel: a cell (cell_i, cell_j, cell_k, corner_invalid) is taken
// at a clock edge with start high and busy low. busy rises only when the
// four-entry request queue is full and a cell with output waits to enter it.
// Result channel: result_strobe marks one simplex per cycle on vertex_a..d,
// is_triangle and last_of_cell; the receiver takes every strobed cycle.
// Path: the first simplex of a cell reaches the result ports through three
// front stages, the queue, the back's cell register and its output register.
// Throughput: the back emits one simplex per cycle while it holds a cell, and
// a cell yields up to six simplices; a cell with none is taken on the request
// channel and leaves no trace.
// Configuration: cfg_we writes register cfg_index (0 size_x, 1 size_y,
// 2 size_z, 3 split_scheme) from cfg_data; write only while the block idles.
// Reset: sizes return to 1 and scheme to 0, the pipe and queue empty, and
// no cell produces output until the sizes are written.
`default_nettype none

module grid_cell_simplex_emitter_top import gcse_pkg::*; #(
	parameter int MAX_AXIS_POINTS = 1024
) (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 start,
	output logic                      busy,
	input  wire logic [CELL_W-1:0]    cell_i,
	input  wire logic [CELL_W-1:0]    cell_j,
	input  wire logic [CELL_W-1:0]    cell_k,
	input  wire logic [MASK_W-1:0]    corner_invalid,
	input  wire logic                 cfg_we,
	input  wire logic [REG_IDX_W-1:0] cfg_index,
	input  wire logic [SIZE_W-1:0]    cfg_data,
	output logic                      result_strobe,
	output logic [VTX_W-1:0]          vertex_a,
	output logic [VTX_W-1:0]          vertex_b,
	output logic [VTX_W-1:0]          vertex_c,
	output logic [VTX_W-1:0]          vertex_d,
	output logic                      is_triangle,
	output logic                      last_of_cell
);

	logic    q_full, q_empty, push, pop;
	entry_t  push_entry, q_head;
	stride_t stride;

	gcse_front #(
		.MAX_AXIS_POINTS(MAX_AXIS_POINTS)
	) u_front (
		.clk            (clk),
		.arst_n         (arst_n),
		.start          (start),
		.busy           (busy),
		.cell_i         (cell_i),
		.cell_j         (cell_j),
		.cell_k         (cell_k),
		.corner_invalid (corner_invalid),
		.cfg_we         (cfg_we),
		.cfg_index      (cfg_index),
		.cfg_data       (cfg_data),
		.q_full         (q_full),
		.push           (push),
		.push_entry     (push_entry),
		.stride         (stride)
	);

	gcse_queue u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.din    (push_entry),
		.pop    (pop),
		.dout   (q_head),
		.full   (q_full),
		.empty  (q_empty)
	);

	gcse_back u_back (
		.clk           (clk),
		.arst_n        (arst_n),
		.stride        (stride),
		.q_empty       (q_empty),
		.q_head        (q_head),
		.pop           (pop),
		.result_strobe (result_strobe),
		.vertex_a      (vertex_a),
		.vertex_b      (vertex_b),
		.vertex_c      (vertex_c),
		.vertex_d      (vertex_d),
		.is_triangle   (is_triangle),
		.last_of_cell  (last_of_cell)
	);

endmodule

`default_nettype wire

@@ sv/gcse_checker.sv @@
`default_nettype none

module gcse_checker import gcse_pkg::*; (
	input wire logic                 clk,
	input wire logic                 arst_n,
	input wire logic                 result_strobe,
	input wire logic [VTX_W-1:0]     vertex_d,
	input wire logic                 is_triangle,
	input wire logic                 last_of_cell
);

	// Triangles carry no fourth vertex
	a_tri_no_d: assert property (@(posedge clk) disable iff (!arst_n)
		result_strobe && is_triangle |-> vertex_d == '0)
		else $error("triangle with nonzero fourth vertex");

	// Simplices of one cell leave back to back
	a_cell_burst: assert property (@(posedge clk) disable iff (!arst_n)
		result_strobe && !last_of_cell |=> result_strobe)
		else $error("gap inside a cell's simplices");

	// One cell never mixes triangles and tetrahedra
	a_cell_kind: assert property (@(posedge clk) disable iff (!arst_n)
		result_strobe && !last_of_cell |=> is_triangle == $past(is_triangle))
		else $error("simplex kind changed within a cell");

endmodule

bind grid_cell_simplex_emitter_top gcse_checker u_gcse_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.result_strobe (result_strobe),
	.vertex_d      (vertex_d),
	.is_triangle   (is_triangle),
	.last_of_cell  (last_of_cell)
);

`default_nettype wire
